// ----- rtl/core/bbh_pkg.sv -----
// shared constants and codes for the buddhabrot orbit histogram
package bbh_pkg;

  localparam int GridSizeDef = 512;
  localparam int MaxIterDef  = 1024;

  localparam int CfgW  = 11;
  localparam int CfgIdxW = 2;
  localparam int StepW = 11;
  localparam int StatW = 3;
  localparam int CntW  = 32;
  localparam int CoordW = 32;
  localparam int BinW  = 9;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_ITER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ITER = 2'd1;

  localparam logic [CfgW-1:0] MinIterRst = 11'd20;
  localparam logic [CfgW-1:0] MaxIterRst = 11'd1024;

  // result status codes
  localparam logic [StatW-1:0] ST_REJECT = 3'd0;
  localparam logic [StatW-1:0] ST_NOESC  = 3'd1;
  localparam logic [StatW-1:0] ST_SHORT  = 3'd2;
  localparam logic [StatW-1:0] ST_ACCUM  = 3'd3;
  localparam logic [StatW-1:0] ST_READ   = 3'd4;

  // fixed point constants in Q28
  localparam longint QOne     = 64'sd1 <<< 28;
  localparam longint QHalf    = 64'sd1 <<< 27;
  localparam longint QQuarter = 64'sd1 <<< 26;
  localparam longint QTwoHalf = 64'sd5 <<< 27;
  localparam longint QTwo     = 64'sd1 <<< 29;

endpackage

// ----- rtl/core/bbh_ram.sv -----
// single port synchronous ram with registered read data
module bbh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/buddhabrot_orbit_histogram.sv -----
// Buddhabrot orbit histogram top level. After reset the block sweeps the histogram
// memory to zero, one counter per cycle over all GRID_SIZE*GRID_SIZE counters, and
// accepts no item meanwhile. A read command reads the histogram counter and then
// captures it into the result. A sample point first runs the bulb and cardioid test
// (states BA, BB, BC, BD), and a rejected point goes straight to its result.
// Otherwise each iteration takes a products step and a compare and update step,
// sharing the z register, and the final escape check does the same. An accumulated
// orbit adds a setup step plus a histogram read and write per recorded orbit point
// for the read-modify-write on its single port. The result is then loaded into
// the output register from the done state. The next item can be
// accepted in the cycle after the result is loaded, and a result that finds the
// output register still full waits for it. One item is in work at a time; a
// finished result waits in the output register while the next item is accepted.
// GRID_SIZE must be a power of two.
module buddhabrot_orbit_histogram #(
  parameter int GRID_SIZE = bbh_pkg::GridSizeDef,
  parameter int MAX_ITER  = bbh_pkg::MaxIterDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bbh_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic signed [bbh_pkg::CoordW-1:0] c_re_i,
  input  logic signed [bbh_pkg::CoordW-1:0] c_im_i,
  input  logic [bbh_pkg::BinW-1:0]      bin_row_i,
  input  logic [bbh_pkg::BinW-1:0]      bin_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbh_pkg::StatW-1:0]     status_o,
  output logic [bbh_pkg::StepW-1:0]     steps_o,
  output logic [bbh_pkg::CntW-1:0]      bin_count_o
);

  import bbh_pkg::*;

  localparam int LG    = $clog2(GRID_SIZE);
  localparam int HW    = 2 * LG;
  localparam int HDEP  = GRID_SIZE * GRID_SIZE;
  localparam int OAW   = $clog2(MAX_ITER);
  localparam int OLW   = $clog2(MAX_ITER + 1);
  localparam int RW    = (LG > BinW) ? LG : BinW;
  localparam int ZW    = 36;

  localparam logic signed [ZW-1:0] ZLim = ZW'(64'sd1 <<< 30);
  localparam logic signed [63:0]   Four = 64'sd1 <<< 58;
  localparam logic signed [66:0]   BulbR = 67'sd1 <<< 52;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDH  = 4'd2;
  localparam logic [3:0] S_RDO  = 4'd3;
  localparam logic [3:0] S_BA   = 4'd4;
  localparam logic [3:0] S_BB   = 4'd5;
  localparam logic [3:0] S_BC   = 4'd6;
  localparam logic [3:0] S_BD   = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_EVAL = 4'd9;
  localparam logic [3:0] S_APRE = 4'd10;
  localparam logic [3:0] S_AH   = 4'd11;
  localparam logic [3:0] S_AW   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_q, state_d;
  logic [CfgW-1:0] min_q, max_q;
  logic [HW-1:0] clr_q;
  logic out_valid_q;
  logic [StatW-1:0] out_status_q;
  logic [StepW-1:0] out_steps_q;
  logic [CntW-1:0]  out_count_q;

  // captured item
  logic cmd_q;
  logic signed [CoordW-1:0] x_q, y_q;
  logic [HW-1:0] rd_idx_q;
  logic rd_inr_q;
  logic [StepW-1:0] lim_q;

  logic [StatW-1:0] res_status_q;
  logic [CntW-1:0]  res_count_q;
  logic [StepW-1:0] steps_q;
  logic [OLW-1:0]   olen_q, k_q;
  logic first_q;
  logic [HW-1:0] cur_idx_q;

  // bulb and cardioid test
  logic signed [32:0] xb, xa;
  logic inr, inr_q, bulb_q;
  logic signed [65:0] bb_q, aa_q, lhs_q;
  logic signed [63:0] yy_q;
  logic signed [66:0] qsum;
  logic signed [31:0] q_c, q_q;
  logic signed [33:0] qa_q;
  logic card;

  // iteration
  logic signed [ZW-1:0] zre_q, zim_q, wre, nre, nim, sum_r, sum_c;
  logic signed [30:0] re31, im31, w31;
  logic signed [61:0] rr_q, ii_q, ri_q, ww_q;
  logic big_q, bigw_q, big_re, big_im, big_w;
  logic signed [63:0] esum, wsum, dif;
  logic lt, le, win, rec_ok, cont;
  logic [LG-1:0] row_v, col_v;

  logic [RW-1:0] rrow, rcol;

  // memory ports
  logic h_en, h_we;
  logic [HW-1:0] h_addr, h_wdata_idx;
  logic [CntW-1:0] h_wdata, h_rdata;
  logic o_en, o_we;
  logic [OAW-1:0] o_addr;
  logic [HW-1:0] o_wdata, o_rdata;

  logic in_fire, out_free;
  logic [OLW-1:0] k_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign k_next = k_q + OLW'(1);

  assign rrow = RW'(bin_row_i);
  assign rcol = RW'(bin_col_i);

  // bulb test arithmetic
  assign xb = 33'(x_q) + 33'(QOne);
  assign xa = 33'(x_q) - 33'(QQuarter);
  assign inr = !(33'(x_q) > 33'(QHalf)) && !(33'(x_q) <= -33'(QOne + QQuarter)) &&
               !(33'(y_q) > 33'(QOne)) && !(33'(y_q) < -33'(QOne));
  assign qsum = 67'(aa_q) + 67'(yy_q);
  assign q_c = 32'(qsum >>> 28);
  assign card = inr_q && (lhs_q < 66'(yy_q >>> 2));

  // products use the low bits, valid whenever the big flags are clear
  assign re31 = zre_q[30:0];
  assign im31 = zim_q[30:0];
  assign wre = zre_q + ZW'(QHalf);
  assign w31 = wre[30:0];
  assign big_re = (zre_q >= ZLim) || (zre_q <= -ZLim);
  assign big_im = (zim_q >= ZLim) || (zim_q <= -ZLim);
  assign big_w  = (wre >= ZLim) || (wre <= -ZLim);

  assign esum = 64'(rr_q) + 64'(ii_q);
  assign wsum = 64'(ww_q) + 64'(ii_q);
  assign lt = !big_q && (esum < Four);
  assign le = !big_q && (esum <= Four);
  assign win = !first_q && !bigw_q && (wsum < Four);
  assign sum_r = zre_q + ZW'(QTwoHalf);
  assign sum_c = zim_q + ZW'(QTwo);
  assign row_v = sum_r[29 -: LG];
  assign col_v = sum_c[29 -: LG];
  assign rec_ok = win && (sum_r[ZW-1:30] == '0) && (sum_c[ZW-1:30] == '0) &&
                  (32'(olen_q) < MAX_ITER);
  assign dif = 64'(rr_q) - 64'(ii_q);
  assign nre = ZW'(dif >>> 28) + ZW'(x_q);
  assign nim = ZW'(64'(ri_q) >>> 27) + ZW'(y_q);
  assign cont = (steps_q < lim_q) && lt;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == HW'(HDEP - 1)) state_d = S_IDLE;
      S_IDLE: if (in_fire) state_d = cmd_i ? S_RDH : S_BA;
      S_RDH:  state_d = S_RDO;
      S_RDO:  state_d = S_DONE;
      S_BA:   state_d = S_BB;
      S_BB:   state_d = S_BC;
      S_BC:   state_d = S_BD;
      S_BD:   state_d = (bulb_q || card) ? S_DONE : S_MUL;
      S_MUL:  state_d = S_EVAL;
      S_EVAL: begin
        if (cont) state_d = S_MUL;
        else if (le || steps_q <= min_q) state_d = S_DONE;
        else state_d = S_APRE;
      end
      S_APRE: state_d = (olen_q == '0) ? S_DONE : S_AH;
      S_AH:   state_d = S_AW;
      S_AW:   state_d = (k_next == olen_q) ? S_DONE : S_AH;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  // histogram port
  always_comb begin
    h_en = 1'b0;
    h_we = 1'b0;
    h_addr = clr_q;
    h_wdata = '0;
    unique case (state_q)
      S_CLR: h_we = 1'b1;
      S_RDH: begin
        h_en = 1'b1;
        h_addr = rd_idx_q;
      end
      S_AH: begin
        h_en = 1'b1;
        h_addr = o_rdata;
      end
      S_AW: begin
        h_we = 1'b1;
        h_addr = cur_idx_q;
        h_wdata = (h_rdata == '1) ? h_rdata : h_rdata + CntW'(1);
      end
      default: ;
    endcase
  end

  assign h_wdata_idx = h_addr;

  // orbit list port
  always_comb begin
    o_en = 1'b0;
    o_we = 1'b0;
    o_addr = olen_q[OAW-1:0];
    o_wdata = {row_v, col_v};
    unique case (state_q)
      S_EVAL: o_we = rec_ok;
      S_APRE: begin
        o_en = 1'b1;
        o_addr = '0;
      end
      S_AH: begin
        o_en = 1'b1;
        o_addr = k_next[OAW-1:0];
      end
      default: ;
    endcase
  end

  bbh_ram #(.Width(CntW), .Depth(HDEP)) u_hist (
    .clk_i   (clk_i),
    .en_i    (h_en),
    .we_i    (h_we),
    .addr_i  (h_wdata_idx),
    .wdata_i (h_wdata),
    .rdata_o (h_rdata)
  );

  bbh_ram #(.Width(HW), .Depth(MAX_ITER)) u_orbit (
    .clk_i   (clk_i),
    .en_i    (o_en),
    .we_i    (o_we),
    .addr_i  (o_addr),
    .wdata_i (o_wdata),
    .rdata_o (o_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      min_q <= MinIterRst;
      max_q <= MaxIterRst;
      out_valid_q <= 1'b0;
      steps_q <= '0;
      olen_q <= '0;
      k_q <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MIN_ITER) min_q <= cfg_data_i;
        else if (cfg_idx_i == CFG_MAX_ITER) max_q <= cfg_data_i;
      end
      if (state_q == S_CLR) clr_q <= clr_q + HW'(1);
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_fire) begin
        steps_q <= '0;
        olen_q <= '0;
        first_q <= 1'b1;
      end
      if (state_q == S_EVAL) begin
        if (rec_ok) olen_q <= olen_q + OLW'(1);
        if (cont) begin
          steps_q <= steps_q + StepW'(1);
          first_q <= 1'b0;
        end
      end
      if (state_q == S_APRE) k_q <= '0;
      if (state_q == S_AW) k_q <= k_next;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      x_q <= c_re_i;
      y_q <= c_im_i;
      rd_idx_q <= {rrow[LG-1:0], rcol[LG-1:0]};
      rd_inr_q <= (32'(bin_row_i) < GRID_SIZE) && (32'(bin_col_i) < GRID_SIZE);
      lim_q <= (32'(max_q) > MAX_ITER) ? StepW'(MAX_ITER) : max_q;
      res_count_q <= '0;
      res_status_q <= cmd_i ? ST_READ : ST_REJECT;
    end
    if (state_q == S_RDO) res_count_q <= rd_inr_q ? h_rdata : '0;
    if (state_q == S_BA) begin
      bb_q <= xb * xb;
      aa_q <= xa * xa;
      yy_q <= y_q * y_q;
      inr_q <= inr;
    end
    if (state_q == S_BB) begin
      bulb_q <= inr_q && ((67'(bb_q) + 67'(yy_q)) < BulbR);
      q_q <= q_c;
      qa_q <= 34'(q_c) + 34'(xa);
    end
    if (state_q == S_BC) lhs_q <= q_q * qa_q;
    if (state_q == S_BD) begin
      zre_q <= ZW'(x_q);
      zim_q <= ZW'(y_q);
    end
    if (state_q == S_MUL) begin
      rr_q <= re31 * re31;
      ii_q <= im31 * im31;
      ri_q <= re31 * im31;
      ww_q <= w31 * w31;
      big_q <= big_re || big_im;
      bigw_q <= big_w || big_im;
    end
    if (state_q == S_EVAL) begin
      if (cont) begin
        zre_q <= nre;
        zim_q <= nim;
      end else if (le) begin
        res_status_q <= ST_NOESC;
      end else if (steps_q <= min_q) begin
        res_status_q <= ST_SHORT;
      end else begin
        res_status_q <= ST_ACCUM;
      end
    end
    if (state_q == S_AH) cur_idx_q <= o_rdata;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_steps_q <= cmd_q ? '0 : steps_q;
      out_count_q <= res_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign steps_o = out_steps_q;
  assign bin_count_o = out_count_q;

endmodule

// ----- rtl/core/bbh_checker.sv -----
// port level checks for the buddhabrot orbit histogram and their binding
module bbh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bbh_pkg::StatW-1:0]     status_o,
  input logic [bbh_pkg::StepW-1:0]     steps_o,
  input logic [bbh_pkg::CntW-1:0]      bin_count_o
);

  import bbh_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(steps_o) && $stable(bin_count_o))
    else $error("result changed while stalled");

  // only read transfers carry a count
  a_count_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_READ |-> bin_count_o == '0)
    else $error("count on non-read result");

  // rejected points and reads do no iteration
  a_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_READ || status_o == ST_REJECT) |-> steps_o == '0)
    else $error("steps on read or rejected result");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

endmodule

bind buddhabrot_orbit_histogram bbh_checker u_bbh_checker (.*);
